// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL that carries concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising edge of clk, held off while rst_n is low.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

// Check prop at every rising edge of clk, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hdl/dgci_pkg.sv =====
// Shared constants and types for the dual gap code-to-index core.
package dgci_pkg;

	localparam int MAX_LENGTH_DEF = 128;
	localparam int INDEX_BITS_DEF = 32;

	localparam int BASE_W      = 8;
	localparam int CHAR_W      = 8;
	localparam int OUT_INDEX_W = 32;
	localparam int CFG_INDEX_W = 8;
	localparam int OUT_DATA_W  = 72;

	localparam logic [BASE_W-1:0] BASE_RESET = 8'd2;

	// Only these two bytes decode to digit one and digit two.
	localparam logic [CHAR_W-1:0] CHAR_ONE = 8'h31;
	localparam logic [CHAR_W-1:0] CHAR_TWO = 8'h32;

	localparam logic [CFG_INDEX_W-1:0] REG_BASE_FIRST  = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_BASE_SECOND = 8'd1;

	typedef struct packed {
		logic                   overflow_flag;
		logic                   invalid_second;
		logic                   invalid_first;
		logic [OUT_INDEX_W-1:0] index_second;
		logic [OUT_INDEX_W-1:0] index_first;
	} res_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

// ===== hdl/dgci_chan.sv =====
// One marker channel: gap counter, weight and mixed-radix accumulator.
module dgci_chan #(
	parameter int INDEX_BITS = dgci_pkg::INDEX_BITS_DEF,
	parameter int MAX_LENGTH = dgci_pkg::MAX_LENGTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  logic                          marker,
	input  logic                          clear,
	input  logic [dgci_pkg::BASE_W-1:0]   base,
	output logic [INDEX_BITS-1:0]         acc_d,
	output logic                          bad_d,
	output logic                          ovf_evt
);

	localparam int GAP_W  = $clog2(MAX_LENGTH + 2);
	localparam int BW     = dgci_pkg::BASE_W;
	localparam int CMP_W  = (GAP_W > BW) ? GAP_W : BW;
	localparam int PD_W   = INDEX_BITS + GAP_W;
	localparam int PW_W   = INDEX_BITS + BW;

	logic [GAP_W-1:0]      gap_q, gap_d;
	logic [INDEX_BITS-1:0] acc_q;
	logic [INDEX_BITS-1:0] wt_q, wt_d;
	logic                  big_q, big_d;
	logic                  bad_q;

	logic [GAP_W-1:0]      digit;
	logic [PD_W-1:0]       prod_full;
	logic [PW_W-1:0]       wprod;
	logic [INDEX_BITS:0]   sum;

	always_comb begin
		digit     = gap_q + GAP_W'(1);
		prod_full = PD_W'(wt_q) * PD_W'(digit);
		wprod     = PW_W'(wt_q) * PW_W'(base);
		sum       = {1'b0, acc_q} + {1'b0, prod_full[INDEX_BITS-1:0]};

		gap_d   = gap_q;
		acc_d   = acc_q;
		wt_d    = wt_q;
		big_d   = big_q;
		bad_d   = bad_q;
		ovf_evt = 1'b0;

		if (!marker) begin
			if (gap_q < GAP_W'(MAX_LENGTH))
				gap_d = gap_q + GAP_W'(1);
		end else begin
			gap_d = '0;
			if (CMP_W'(digit) >= CMP_W'(base))
				bad_d = 1'b1;
			if (big_q) begin
				// saturated weight: product vanishes modulo the index width
				ovf_evt = 1'b1;
			end else begin
				ovf_evt = (|prod_full[PD_W-1:INDEX_BITS]) | sum[INDEX_BITS];
				acc_d   = sum[INDEX_BITS-1:0];
				if (base == '0) begin
					wt_d = '0;
				end else if (|wprod[PW_W-1:INDEX_BITS]) begin
					big_d = 1'b1;
					wt_d  = '0;
				end else begin
					wt_d = wprod[INDEX_BITS-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q <= '0;
			acc_q <= '0;
			wt_q  <= INDEX_BITS'(1);
			big_q <= 1'b0;
			bad_q <= 1'b0;
		end else if (step) begin
			if (clear) begin
				gap_q <= '0;
				acc_q <= '0;
				wt_q  <= INDEX_BITS'(1);
				big_q <= 1'b0;
				bad_q <= 1'b0;
			end else begin
				gap_q <= gap_d;
				acc_q <= acc_d;
				wt_q  <= wt_d;
				big_q <= big_d;
				bad_q <= bad_d;
			end
		end
	end

endmodule

// ===== hdl/dgci_outq.sv =====
// Two-entry result queue: output register plus skid entry.
module dgci_outq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  dgci_pkg::res_t        push_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output dgci_pkg::res_t        out_data,
	output dgci_pkg::q_stat_t     stat
);

	dgci_pkg::res_t mem_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     cnt_q;
	logic           pop;

	assign pop        = out_valid && out_ready;
	assign out_valid  = (cnt_q != 2'd0);
	assign stat.full  = (cnt_q == 2'd2);
	assign stat.empty = (cnt_q == 2'd0);

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk) begin
		out_data <= push_data;
		// with both entries held, the younger one sits behind the head
		if (pop && cnt_q == 2'd2)
			out_data <= mem_q[~rd_ptr_q];
		else if (!pop && cnt_q != 2'd0)
			out_data <= mem_q[rd_ptr_q];
		else if (pop && cnt_q == 2'd1 && !push)
			out_data <= mem_q[rd_ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== hdl/dual_gap_code_to_index_core.sv =====
// Top level of the dual gap code-to-index core.
//
//  channel   dir  beat contents
//  -------   ---  -------------------------------------------------------------
//  s_axis    in   tdata[7:0] char_code, tlast last_char
//  m_axis    out  tdata: index_first, index_second, invalid_first,
//                 invalid_second, overflow_flag (from bit 0 up)
//  cfg       in   cfg_index selects base_first (0) or base_second (1)
//
// One character per cycle unless stalled: an input register, then one
// multiply-accumulate per channel into the state and result registers. Reset
// clears both channels and sets both bases to 2. The input stalls only when a
// last character meets a full two-entry result queue; other characters pass while
// results wait.
`include "assert_macros.svh"

module dual_gap_code_to_index_core #(
	parameter int INDEX_BITS = dgci_pkg::INDEX_BITS_DEF,
	parameter int MAX_LENGTH = dgci_pkg::MAX_LENGTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  logic [dgci_pkg::CHAR_W-1:0]          s_axis_tdata,  // [7:0] char_code
	input  logic                                 s_axis_tlast,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// [31:0] index_first, [63:32] index_second, [64] invalid_first,
	// [65] invalid_second, [66] overflow_flag, [71:67] zero
	output logic [dgci_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [dgci_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [dgci_pkg::BASE_W-1:0]          cfg_data
);

	logic [dgci_pkg::BASE_W-1:0] base_first_q;
	logic [dgci_pkg::BASE_W-1:0] base_second_q;

	logic                        v_s1;
	logic [dgci_pkg::CHAR_W-1:0] char_s1;
	logic                        last_s1;

	logic                        hold_last;
	logic                        advance;
	logic                        push;
	logic                        overflow_seen_q;

	logic [INDEX_BITS-1:0]       acc_first_d;
	logic [INDEX_BITS-1:0]       acc_second_d;
	logic                        bad_first_d;
	logic                        bad_second_d;
	logic                        ovf_first;
	logic                        ovf_second;

	dgci_pkg::res_t              res;
	dgci_pkg::res_t              q_data;
	dgci_pkg::q_stat_t           q_stat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_first_q  <= dgci_pkg::BASE_RESET;
			base_second_q <= dgci_pkg::BASE_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				dgci_pkg::REG_BASE_FIRST:  base_first_q  <= cfg_data;
				dgci_pkg::REG_BASE_SECOND: base_second_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// hold a last character until the result queue has room
	assign hold_last     = v_s1 && last_s1 && q_stat.full;
	assign advance       = v_s1 && !hold_last;
	assign push          = advance && last_s1;
	assign s_axis_tready = !v_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (s_axis_tready)
			v_s1 <= s_axis_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			char_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	dgci_chan #(
		.INDEX_BITS (INDEX_BITS),
		.MAX_LENGTH (MAX_LENGTH)
	) u_chan_first (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.marker  (char_s1 == dgci_pkg::CHAR_ONE),
		.clear   (last_s1),
		.base    (base_first_q),
		.acc_d   (acc_first_d),
		.bad_d   (bad_first_d),
		.ovf_evt (ovf_first)
	);

	dgci_chan #(
		.INDEX_BITS (INDEX_BITS),
		.MAX_LENGTH (MAX_LENGTH)
	) u_chan_second (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.marker  (char_s1 == dgci_pkg::CHAR_TWO),
		.clear   (last_s1),
		.base    (base_second_q),
		.acc_d   (acc_second_d),
		.bad_d   (bad_second_d),
		.ovf_evt (ovf_second)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			overflow_seen_q <= 1'b0;
		else if (advance)
			overflow_seen_q <= last_s1 ? 1'b0 : (overflow_seen_q | ovf_first | ovf_second);
	end

	always_comb begin
		res.index_first    = 32'(acc_first_d);
		res.index_second   = 32'(acc_second_d);
		res.invalid_first  = bad_first_d;
		res.invalid_second = bad_second_d;
		res.overflow_flag  = overflow_seen_q | ovf_first | ovf_second;
	end

	dgci_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (res),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (q_data),
		.stat      (q_stat)
	);

	assign m_axis_tdata = dgci_pkg::OUT_DATA_W'(q_data);

	`ASSERT_CLK(a_last_stalls, clk, arst_n, hold_last |-> !s_axis_tready, "last beat on full queue")
	`ASSERT_CLK(a_full_valid, clk, arst_n, q_stat.full |-> m_axis_tvalid, "full queue not valid")
	`ASSERT_CLK(a_empty_idle, clk, arst_n, q_stat.empty |-> !m_axis_tvalid, "empty queue valid")
	`ASSERT_CLK(a_ovf_clear, clk, arst_n, push |=> !overflow_seen_q, "overflow kept past a string")

endmodule
